// ===== rtl/ghbacp_pkg.sv =====
// Package for the GHB address-correlation prefetcher.
// Shared constants and transfer types. No dependencies.
`default_nettype none
package ghbacp_pkg;
    localparam int HISTORY_DEPTH_DEF  = 256;
    localparam int INDEX_ENTRIES_DEF  = 1024;
    localparam int WALK_DEPTH_DEF     = 1;
    localparam int PF_DEGREE_DEF      = 1;
    localparam int ADDR_W             = 64;
    localparam int OCC_W              = 6;
    localparam logic [OCC_W-1:0] THRESHOLD_RESET = 6'd8;
    // Pointers travel at the width of the largest ring / table allowed.
    localparam int PTR_W              = 12;
    localparam int CLR_W              = 13;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              level;
        logic              hit;
        logic [PTR_W-1:0]  ptr;
        logic [PTR_W-1:0]  head;
    } t_job;

    typedef struct packed {
        logic [ADDR_W-1:0] trigger_addr;
        logic [ADDR_W-1:0] prefetch_addr;
        logic              fill_level;
        logic              last;
    } t_res;

    typedef struct packed {
        logic             en;
        logic [CLR_W-1:0] addr;
    } t_clr;
endpackage
`default_nettype wire

// ===== rtl/ghb_address_correlation_prefetcher.sv =====
// Top level: GHB address-correlation prefetcher. Depends on ghbacp_pkg, ghbacp_fifo,
// ghbacp_front, ghbacp_back.
// Front: per access, an index read and then an index update; the next access is taken when idle.
// Back: a miss writes the history ring and returns to idle; a hit also walks the chain, each
// step reading PF_DEGREE results through the single read port of the history ring.
// Reset: clearing pass over max(HISTORY_DEPTH, INDEX_ENTRIES) entries (1024 by default), full high.
`default_nettype none
module ghb_address_correlation_prefetcher #(
    parameter int HISTORY_DEPTH  = ghbacp_pkg::HISTORY_DEPTH_DEF,
    parameter int INDEX_ENTRIES  = ghbacp_pkg::INDEX_ENTRIES_DEF,
    parameter int WALK_DEPTH     = ghbacp_pkg::WALK_DEPTH_DEF,
    parameter int PF_DEGREE      = ghbacp_pkg::PF_DEGREE_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            push,
    output logic                           full,
    input  wire  [ghbacp_pkg::ADDR_W-1:0]  i_access_addr,
    input  wire  [ghbacp_pkg::ADDR_W-1:0]  i_instruction_pointer,
    input  wire  [ghbacp_pkg::OCC_W-1:0]   i_mshr_occupancy,
    output logic                           empty,
    input  wire                            pop,
    output logic [ghbacp_pkg::ADDR_W-1:0]  o_trigger_addr,
    output logic [ghbacp_pkg::ADDR_W-1:0]  o_prefetch_addr,
    output logic                           o_fill_level,
    output logic                           o_last,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [2:0]                     paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    localparam int OW = ghbacp_pkg::OCC_W;

    logic [OW-1:0]     r_threshold;
    logic              job_push, job_full, job_empty, job_pop;
    ghbacp_pkg::t_job  job_in, job_out;
    logic              res_push, res_full;
    ghbacp_pkg::t_res  res_in, res_out;
    ghbacp_pkg::t_clr  clr;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - OW){1'b0}}, r_threshold} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ghbacp_pkg::THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_threshold <= pwdata[OW-1:0];
        end
    end

    ghbacp_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .INDEX_ENTRIES (INDEX_ENTRIES)
    ) u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_push                (push),
        .o_full                (full),
        .i_access_addr         (i_access_addr),
        .i_instruction_pointer (i_instruction_pointer),
        .i_mshr_occupancy      (i_mshr_occupancy),
        .i_fill_threshold      (r_threshold),
        .o_job_push            (job_push),
        .o_job                 (job_in),
        .i_job_full            (job_full),
        .o_clr                 (clr)
    );

    ghbacp_fifo #(
        .T     (ghbacp_pkg::t_job),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    ghbacp_back #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .WALK_DEPTH     (WALK_DEPTH),
        .PF_DEGREE      (PF_DEGREE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (clr),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    ghbacp_fifo #(
        .T     (ghbacp_pkg::t_res),
        .DEPTH (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_trigger_addr  = res_out.trigger_addr;
    assign o_prefetch_addr = res_out.prefetch_addr;
    assign o_fill_level    = res_out.fill_level;
    assign o_last          = res_out.last;

    a_clear_blocks: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("input not blocked during clearing pass");
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result transfer into full queue");
    a_job_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !job_full)
        else $error("job transfer into full queue");
endmodule
`default_nettype wire

// ===== rtl/ghbacp_fifo.sv =====
// Small register FIFO used for the job queue and the result queue.
// Depends on nothing but its type parameter.
`default_nettype none
module ghbacp_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  T     i_data,
    output logic o_full,
    input  wire  i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ghbacp_front.sv =====
// Front end: accepts accesses, looks up and updates the index table, owns the head.
// Runs the clearing pass after reset. Depends on ghbacp_pkg.
`default_nettype none
module ghbacp_front #(
    parameter int HISTORY_DEPTH = ghbacp_pkg::HISTORY_DEPTH_DEF,
    parameter int INDEX_ENTRIES = ghbacp_pkg::INDEX_ENTRIES_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_push,
    output logic                            o_full,
    input  wire  [ghbacp_pkg::ADDR_W-1:0]   i_access_addr,
    input  wire  [ghbacp_pkg::ADDR_W-1:0]   i_instruction_pointer,
    input  wire  [ghbacp_pkg::OCC_W-1:0]    i_mshr_occupancy,
    input  wire  [ghbacp_pkg::OCC_W-1:0]    i_fill_threshold,
    output logic                            o_job_push,
    output ghbacp_pkg::t_job                o_job,
    input  wire                             i_job_full,
    output ghbacp_pkg::t_clr                o_clr
);
    localparam int HPW  = $clog2(HISTORY_DEPTH);
    localparam int IW   = $clog2(INDEX_ENTRIES);
    localparam int MAXD = (HISTORY_DEPTH > INDEX_ENTRIES) ? HISTORY_DEPTH : INDEX_ENTRIES;
    localparam int CW   = $clog2(MAXD);
    localparam int PTRW = ghbacp_pkg::PTR_W;
    localparam int CLRW = ghbacp_pkg::CLR_W;

    typedef enum logic [1:0] {F_CLR, F_IDLE, F_LOOK} t_fstate;

    t_fstate                      r_state;
    logic [CW-1:0]                r_cnt;
    logic [HPW-1:0]               r_head;
    logic [ghbacp_pkg::ADDR_W-1:0] r_addr;
    logic                         r_level;
    logic [IW-1:0]                r_slot;

    logic                          idx_valid [INDEX_ENTRIES];
    logic [ghbacp_pkg::ADDR_W-1:0] idx_tag   [INDEX_ENTRIES];
    logic [HPW-1:0]                idx_ptr   [INDEX_ENTRIES];
    logic                          r_q_valid;
    logic [ghbacp_pkg::ADDR_W-1:0] r_q_tag;
    logic [HPW-1:0]                r_q_ptr;

    logic accept, hit, look_go;

    assign o_full  = (r_state != F_IDLE);
    assign accept  = i_push && (r_state == F_IDLE);
    assign hit     = r_q_valid && (r_q_tag == r_addr);
    assign look_go = (r_state == F_LOOK) && !i_job_full;

    assign o_job_push = look_go;
    assign o_job      = '{addr: r_addr, level: r_level, hit: hit,
                          ptr: PTRW'(r_q_ptr), head: PTRW'(r_head)};
    assign o_clr      = '{en: (r_state == F_CLR), addr: CLRW'(r_cnt)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_CLR;
            r_cnt   <= '0;
            r_head  <= '0;
        end else begin
            case (r_state)
                F_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(MAXD - 1)) begin
                        r_state <= F_IDLE;
                    end
                end
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_LOOK;
                    end
                end
                F_LOOK: begin
                    if (look_go) begin
                        r_head  <= (r_head == HPW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_CLR;
            endcase
        end
        if (accept) begin
            r_addr  <= i_access_addr;
            r_level <= (i_mshr_occupancy >= i_fill_threshold);
            r_slot  <= i_instruction_pointer[IW-1:0];
        end
    end

    // Index table
    always_ff @(posedge i_clk) begin
        if (r_state == F_CLR) begin
            if (r_cnt < CW'(INDEX_ENTRIES) || MAXD == INDEX_ENTRIES) begin
                idx_valid[r_cnt[IW-1:0]] <= 1'b0;
            end
        end else if (look_go) begin
            idx_valid[r_slot] <= 1'b1;
            idx_tag[r_slot]   <= r_addr;
            idx_ptr[r_slot]   <= r_head;
        end
        if (accept) begin
            r_q_valid <= idx_valid[i_instruction_pointer[IW-1:0]];
            r_q_tag   <= idx_tag[i_instruction_pointer[IW-1:0]];
            r_q_ptr   <= idx_ptr[i_instruction_pointer[IW-1:0]];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ghbacp_back.sv =====
// Back end: writes the history ring and walks the correlation chain.
// Emits prefetch results; holds the newest one back to mark the last. Depends on ghbacp_pkg.
`default_nettype none
module ghbacp_back #(
    parameter int HISTORY_DEPTH  = ghbacp_pkg::HISTORY_DEPTH_DEF,
    parameter int WALK_DEPTH     = ghbacp_pkg::WALK_DEPTH_DEF,
    parameter int PF_DEGREE      = ghbacp_pkg::PF_DEGREE_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ghbacp_pkg::t_clr  i_clr,
    input  wire               i_job_empty,
    input  ghbacp_pkg::t_job  i_job,
    output logic              o_job_pop,
    input  wire               i_res_full,
    output logic              o_res_push,
    output ghbacp_pkg::t_res  o_res
);
    localparam int HPW  = $clog2(HISTORY_DEPTH);
    localparam int DW   = HPW + 2;
    localparam int SW   = $clog2(WALK_DEPTH + 1);
    localparam int KW   = $clog2(PF_DEGREE + 1);
    localparam int CLRW = ghbacp_pkg::CLR_W;
    localparam int AW   = ghbacp_pkg::ADDR_W;

    typedef enum logic [2:0] {B_IDLE, B_WRITE, B_STEP, B_EMIT, B_MATCH, B_FIN} t_bstate;

    t_bstate           r_state, n_state;
    ghbacp_pkg::t_job  r_job, n_job;
    logic [HPW-1:0]    r_cur, n_cur, r_prev, n_prev, r_nx, n_nx;
    logic [DW-1:0]     r_dist, n_dist;
    logic [SW-1:0]     r_steps, n_steps;
    logic [KW-1:0]     r_k, n_k;
    logic              r_match, n_match;
    logic              r_pend_v, n_pend_v;
    ghbacp_pkg::t_res  r_pend, n_pend;

    logic [AW-1:0]     hist [HISTORY_DEPTH];
    logic [HPW-1:0]    link [HISTORY_DEPTH];
    logic [AW-1:0]     r_hq;
    logic [HPW-1:0]    r_lq;

    logic              hist_we, hist_re, link_we, link_re;
    logic [HPW-1:0]    hist_wa, link_wa, link_wd, link_ra;
    logic [AW-1:0]     hist_wd;
    logic [DW-1:0]     dstep, ndist;
    logic [HPW-1:0]    head, jptr;

    function automatic logic [HPW-1:0] ring_inc(input logic [HPW-1:0] x);
        ring_inc = (x == HPW'(HISTORY_DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    assign head  = r_job.head[HPW-1:0];
    assign jptr  = r_job.ptr[HPW-1:0];
    assign dstep = (r_cur > r_prev) ? DW'(r_cur) - DW'(r_prev)
                                    : DW'(r_cur) + DW'(HISTORY_DEPTH) - DW'(r_prev);
    assign ndist = r_dist + dstep;

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_nx     = r_nx;
        n_dist   = r_dist;
        n_steps  = r_steps;
        n_k      = r_k;
        n_match  = r_match;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = r_pend;
        hist_we  = i_clr.en && (i_clr.addr < CLRW'(HISTORY_DEPTH));
        hist_wa  = i_clr.addr[HPW-1:0];
        hist_wd  = '0;
        hist_re  = 1'b0;
        link_we  = 1'b0;
        link_wa  = head;
        link_wd  = head;
        link_re  = 1'b0;
        link_ra  = r_prev;
        case (r_state)
            B_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_state   = B_WRITE;
                end
            end
            B_WRITE: begin
                hist_we = 1'b1;
                hist_wa = head;
                hist_wd = r_job.addr;
                link_we = 1'b1;
                link_wd = r_job.hit ? jptr : head;
                if (r_job.hit) begin
                    n_cur   = head;
                    n_prev  = jptr;
                    n_dist  = '0;
                    n_steps = '0;
                    n_match = 1'b1;
                    n_state = B_STEP;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_STEP: begin
                if (!r_match || r_prev == r_cur || ndist > DW'(HISTORY_DEPTH)
                        || r_steps == SW'(WALK_DEPTH)) begin
                    n_state = B_FIN;
                end else begin
                    n_dist  = ndist;
                    n_cur   = r_prev;
                    link_re = 1'b1;
                    hist_re = 1'b1;
                    n_nx    = ring_inc(r_prev);
                    n_k     = KW'(1);
                    n_steps = r_steps + 1'b1;
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (!r_pend_v || !i_res_full) begin
                    o_res_push = r_pend_v;
                    n_pend_v   = 1'b1;
                    n_pend     = '{trigger_addr: r_job.addr, prefetch_addr: r_hq,
                                   fill_level: r_job.level, last: 1'b0};
                    hist_re    = 1'b1;
                    if (r_k == KW'(PF_DEGREE)) begin
                        n_nx    = r_cur;
                        n_state = B_MATCH;
                    end else begin
                        n_nx = ring_inc(r_nx);
                        n_k  = r_k + 1'b1;
                    end
                end
            end
            B_MATCH: begin
                n_match = (r_hq == r_job.addr);
                n_prev  = r_lq;
                n_state = B_STEP;
            end
            B_FIN: begin
                if (!r_pend_v) begin
                    n_state = B_IDLE;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res.last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
        end
        r_job   <= n_job;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_nx    <= n_nx;
        r_dist  <= n_dist;
        r_steps <= n_steps;
        r_k     <= n_k;
        r_match <= n_match;
        r_pend  <= n_pend;
    end

    // History ring
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist[hist_wa] <= hist_wd;
        end
        if (hist_re) begin
            r_hq <= hist[n_nx];
        end
        if (link_we) begin
            link[link_wa] <= link_wd;
        end
        if (link_re) begin
            r_lq <= link[link_ra];
        end
    end
endmodule
`default_nettype wire
